### design/tpcr_pkg.sv
// Shared types, codes and constants of the text packet command receiver.
`default_nettype none

package tpcr_pkg;

    // Payload capacity default and command word lengths
    localparam int MAX_PAYLOAD_DEFAULT = 128;
    localparam logic [7:0] ON_LEN  = 8'd6;
    localparam logic [7:0] OFF_LEN = 8'd7;

    // Configuration register reset values
    localparam logic [7:0] HEADER_RESET     = 8'h40;
    localparam logic [7:0] FIRST_END_RESET  = 8'h0D;
    localparam logic [7:0] SECOND_END_RESET = 8'h0A;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_HEADER     = 2'd0;
    localparam cfg_index_t REG_FIRST_END  = 2'd1;
    localparam cfg_index_t REG_SECOND_END = 2'd2;

    // Event queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_ON      = 2'd0,
        CMD_OFF     = 2'd1,
        CMD_UNKNOWN = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        EV_OPEN  = 2'd0,
        EV_DATA  = 2'd1,
        EV_CLOSE = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] data;
    } event_t;

    // Characters of "LED_ON", indexed by payload position
    function automatic logic [7:0] on_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h4C;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h5F;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of "LED_OFF", indexed by payload position
    function automatic logic [7:0] off_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h4C;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h5F;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h46;
            3'd6:    c = 8'h46;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/tpcr_ifs.sv
// Channel interfaces: received bytes, packet results and configuration writes.
`default_nettype none

interface tpcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tpcr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_code;
    logic       led_lit;
    logic [7:0] payload_length;
    logic       overflow;

    modport source (output valid, output command_code, output led_lit,
                    output payload_length, output overflow, input ready);
    modport sink (input valid, input command_code, input led_lit,
                  input payload_length, input overflow, output ready);
endinterface

interface tpcr_cfg_if;
    logic                  valid;
    logic                  ready;
    tpcr_pkg::cfg_index_t  index;
    logic [7:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/text_packet_command_receiver_top.sv
// Top level of the text packet command receiver.
// Accepts one received byte per clock cycle on rx; sustained rate is one byte
// per cycle while the queue is not full. A front end tracks framing (header,
// payload, first and second end bytes) and pushes open, data and close events
// into a four-entry queue; a packet engine drains one event per cycle unless a
// close meets a full result register, matching the payload against "LED_ON"
// and "LED_OFF" and counting bytes up to MAX_PAYLOAD. A result is registered:
// the close event queues behind any earlier events, is loaded into an output
// register and held there until taken; bytes keep flowing while it waits, and
// rx stalls only when the queue fills behind a result that is not taken.
// Configuration writes on cfg are always accepted; index 3 is ignored.
`default_nettype none

module text_packet_command_receiver_top #(
    parameter int MAX_PAYLOAD = tpcr_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tpcr_rx_if.sink         rx,
    tpcr_cfg_if.sink        cfg,
    tpcr_result_if.source   result
);

    logic             push_valid;
    tpcr_pkg::event_t push_ev;
    logic             queue_full;
    logic             pop_valid;
    tpcr_pkg::event_t pop_ev;
    logic             pop_ready;

    tpcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_ev    (push_ev)
    );

    tpcr_queue #(
        .DEPTH (tpcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ev    (push_ev),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ev     (pop_ev),
        .pop_ready  (pop_ready)
    );

    tpcr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ev    (pop_ev),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

### design/tpcr_front.sv
// Front end: framing state, configuration registers and byte classification.
`default_nettype none

module tpcr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tpcr_rx_if.sink            rx,
    tpcr_cfg_if.sink           cfg,
    input  wire logic          queue_full,
    output logic               push_valid,
    output tpcr_pkg::event_t   push_ev
);

    typedef enum logic [1:0] {
        PH_WAIT_HDR = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_WAIT_END = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg;
    logic [7:0] first_end_reg;
    logic [7:0] second_end_reg;
    logic       take;

    assign rx.ready  = !queue_full;
    assign cfg.ready = 1'b1;
    assign take      = rx.valid && rx.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        push_valid   = 1'b0;
        push_ev.kind = tpcr_pkg::EV_DATA;
        push_ev.data = rx.rx_byte;
        if (take)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (rx.rx_byte == first_end_reg)
                        phase_next = PH_WAIT_END;
                    else
                        push_valid = 1'b1;
                end
                PH_WAIT_END:
                begin
                    // drop everything but the closing byte
                    if (rx.rx_byte == second_end_reg)
                    begin
                        phase_next   = PH_WAIT_HDR;
                        push_valid   = 1'b1;
                        push_ev.kind = tpcr_pkg::EV_CLOSE;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_HDR;
                    if (rx.rx_byte == header_reg)
                    begin
                        phase_next   = PH_PAYLOAD;
                        push_valid   = 1'b1;
                        push_ev.kind = tpcr_pkg::EV_OPEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_HDR;
            header_reg     <= tpcr_pkg::HEADER_RESET;
            first_end_reg  <= tpcr_pkg::FIRST_END_RESET;
            second_end_reg <= tpcr_pkg::SECOND_END_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    tpcr_pkg::REG_HEADER:     header_reg     <= cfg.data;
                    tpcr_pkg::REG_FIRST_END:  first_end_reg  <= cfg.data;
                    tpcr_pkg::REG_SECOND_END: second_end_reg <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### design/tpcr_queue.sv
// Short event queue between the front end and the packet engine.
`default_nettype none

module tpcr_queue #(
    parameter int DEPTH = tpcr_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  tpcr_pkg::event_t       push_ev,
    output logic                   full,
    output logic                   pop_valid,
    output tpcr_pkg::event_t       pop_ev,
    input  wire logic              pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpcr_pkg::event_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_ev    = mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
            n = '0;
        else
            n = p + 1'b1;
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

### design/tpcr_back.sv
// Packet engine: payload counting, command matching, LED state and result register.
`default_nettype none

module tpcr_back #(
    parameter int MAX_PAYLOAD = tpcr_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    input  tpcr_pkg::event_t   pop_ev,
    output logic               pop_ready,
    tpcr_result_if.source      result
);

    localparam logic [7:0] CAPACITY = 8'(MAX_PAYLOAD);

    logic [7:0]          count_reg;
    logic                on_alive_reg, off_alive_reg;
    logic                ovf_reg;
    logic                led_reg;
    logic                led_next;
    logic                out_valid_reg;
    tpcr_pkg::cmd_code_t code_reg, code_next;
    logic [7:0]          len_reg;
    logic                out_ovf_reg;
    logic                take;
    logic                on_hit, off_hit;

    assign result.valid          = out_valid_reg;
    assign result.command_code   = code_reg;
    assign result.led_lit        = led_reg;
    assign result.payload_length = len_reg;
    assign result.overflow       = out_ovf_reg;

    // only a close needs room in the result register
    assign pop_ready = (pop_ev.kind != tpcr_pkg::EV_CLOSE) || !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    assign on_hit  = (count_reg < tpcr_pkg::ON_LEN)
                  && (tpcr_pkg::on_char(count_reg[2:0]) == pop_ev.data);
    assign off_hit = (count_reg < tpcr_pkg::OFF_LEN)
                  && (tpcr_pkg::off_char(count_reg[2:0]) == pop_ev.data);

    always_comb
    begin
        code_next = tpcr_pkg::CMD_UNKNOWN;
        led_next  = led_reg;
        if (!ovf_reg)
        begin
            if (on_alive_reg && count_reg == tpcr_pkg::ON_LEN)
                code_next = tpcr_pkg::CMD_ON;
            else if (off_alive_reg && count_reg == tpcr_pkg::OFF_LEN)
                code_next = tpcr_pkg::CMD_OFF;
        end
        if (code_next == tpcr_pkg::CMD_ON)
            led_next = 1'b1;
        else if (code_next == tpcr_pkg::CMD_OFF)
            led_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            on_alive_reg  <= 1'b1;
            off_alive_reg <= 1'b1;
            ovf_reg       <= 1'b0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && pop_ev.kind == tpcr_pkg::EV_CLOSE)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                unique case (pop_ev.kind)
                    tpcr_pkg::EV_OPEN:
                    begin
                        count_reg     <= '0;
                        on_alive_reg  <= 1'b1;
                        off_alive_reg <= 1'b1;
                        ovf_reg       <= 1'b0;
                    end
                    tpcr_pkg::EV_DATA:
                    begin
                        if (count_reg >= CAPACITY)
                            ovf_reg <= 1'b1;
                        else
                        begin
                            on_alive_reg  <= on_alive_reg && on_hit;
                            off_alive_reg <= off_alive_reg && off_hit;
                            count_reg     <= count_reg + 1'b1;
                        end
                    end
                    tpcr_pkg::EV_CLOSE:
                    begin
                        led_reg <= led_next;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result payload, loaded on a close
    always_ff @(posedge clk)
    begin
        if (take && pop_ev.kind == tpcr_pkg::EV_CLOSE)
        begin
            code_reg    <= code_next;
            len_reg     <= count_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the text packet command receiver: byte stream in, packet results out.
module tb_top;
    import tpcr_pkg::*;

    localparam int CAPACITY = MAX_PAYLOAD_DEFAULT;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 400;
    localparam int unsigned BYTES_PER_PHASE = 230;
    localparam cfg_index_t REG_UNUSED = 2'd3;
    localparam logic [47:0] ON_WORD = "LED_ON";
    localparam logic [55:0] OFF_WORD = "LED_OFF";

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2,
        PH_SPARE   = 2'd3
    } frame_phase_t;

    typedef struct {
        cmd_code_t  code;
        logic       led;
        logic [7:0] length;
        logic       ovf;
    } packet_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic       rx_valid_q = 1'b0;
    logic [7:0] rx_byte_q = 8'h00;
    logic       ready_q = 1'b0;
    logic       cfg_valid_q = 1'b0;
    cfg_index_t cfg_index_q = REG_HEADER;
    logic [7:0] cfg_data_q = 8'h00;
    logic       steady_flow = 1'b0;
    int unsigned hold_epoch = 0;

    tpcr_rx_if     rx_ch();
    tpcr_cfg_if    cfg_ch();
    tpcr_result_if result_ch();

    assign rx_ch.valid     = rx_valid_q;
    assign rx_ch.rx_byte   = rx_byte_q;
    assign cfg_ch.valid    = cfg_valid_q;
    assign cfg_ch.index    = cfg_index_q;
    assign cfg_ch.data     = cfg_data_q;
    assign result_ch.ready = ready_q;

    text_packet_command_receiver_top #(
        .MAX_PAYLOAD(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .cfg(cfg_ch),
        .result(result_ch)
    );

    // Register values the block should hold
    logic [7:0] cfg_header = HEADER_RESET;
    logic [7:0] cfg_first_end = FIRST_END_RESET;
    logic [7:0] cfg_second_end = SECOND_END_RESET;

    // Framing state of the packet being tracked
    frame_phase_t phase_now = PH_HUNT;
    int   payload_count = 0;
    logic on_alive = 1'b1;
    logic off_alive = 1'b1;
    logic ovf_seen = 1'b0;
    logic led_now = 1'b0;

    logic [7:0]     rx_backlog[$];
    packet_result_t results_due[$];
    int unsigned    bytes_queued = 0;
    int unsigned    bytes_taken = 0;
    int unsigned    results_checked = 0;
    int             error_count = 0;

    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int unsigned hold_epoch_seen = 0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] command_char(input cmd_code_t which, input int pos);
        if (which == CMD_ON)
            return ON_WORD[8 * (int'(ON_LEN) - 1 - pos) +: 8];
        return OFF_WORD[8 * (int'(OFF_LEN) - 1 - pos) +: 8];
    endfunction

    function automatic logic [7:0] payload_filler();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cfg_first_end);
        return b;
    endfunction

    // Advance the framing state by one accepted byte; a completed packet yields a result
    task automatic decode_rx_byte(input logic [7:0] b);
        packet_result_t res;
        case (phase_now)
            PH_PAYLOAD:
            begin
                if (b == cfg_first_end)
                    phase_now = PH_TRAILER;
                else if (payload_count >= CAPACITY)
                    ovf_seen = 1'b1;
                else
                begin
                    if (payload_count >= ON_LEN)
                        on_alive = 1'b0;
                    else if (b != command_char(CMD_ON, payload_count))
                        on_alive = 1'b0;
                    if (payload_count >= OFF_LEN)
                        off_alive = 1'b0;
                    else if (b != command_char(CMD_OFF, payload_count))
                        off_alive = 1'b0;
                    payload_count++;
                end
            end
            PH_TRAILER:
            begin
                if (b == cfg_second_end)
                begin
                    res.code = CMD_UNKNOWN;
                    if (!ovf_seen && on_alive && payload_count == ON_LEN)
                        res.code = CMD_ON;
                    else if (!ovf_seen && off_alive && payload_count == OFF_LEN)
                        res.code = CMD_OFF;
                    if (res.code == CMD_ON)
                        led_now = 1'b1;
                    else if (res.code == CMD_OFF)
                        led_now = 1'b0;
                    res.led = led_now;
                    res.length = 8'(payload_count);
                    res.ovf = ovf_seen;
                    results_due.push_back(res);
                    phase_now = PH_HUNT;
                end
            end
            default:
            begin
                phase_now = PH_HUNT;
                if (b == cfg_header)
                begin
                    phase_now = PH_PAYLOAD;
                    payload_count = 0;
                    on_alive = 1'b1;
                    off_alive = 1'b1;
                    ovf_seen = 1'b0;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t ns: packet result %0d: %s is %0d, expected %0d",
                 $time, results_checked, what, got, want);
    endtask

    task automatic check_result();
        packet_result_t want;
        results_checked++;
        if (results_due.size() == 0)
        begin
            report_mismatch("unrequested result, command_code",
                            int'(result_ch.command_code), -1);
            return;
        end
        want = results_due.pop_front();
        if (result_ch.command_code !== 2'(want.code))
            report_mismatch("command_code", int'(result_ch.command_code), int'(want.code));
        if (result_ch.led_lit !== want.led)
            report_mismatch("led_lit", int'(result_ch.led_lit), int'(want.led));
        if (result_ch.payload_length !== want.length)
            report_mismatch("payload_length", int'(result_ch.payload_length),
                            int'(want.length));
        if (result_ch.overflow !== want.ovf)
            report_mismatch("overflow", int'(result_ch.overflow), int'(want.ovf));
    endtask

    // Byte driver: one request per accepted byte, random gaps between requests
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_valid_q <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (rx_valid_q && rx_ch.ready)
            begin
                decode_rx_byte(rx_byte_q);
                bytes_taken++;
            end
            if (!rx_valid_q || rx_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    rx_valid_q <= 1'b0;
                end
                else if (rx_backlog.size() != 0)
                begin
                    rx_valid_q <= 1'b1;
                    rx_byte_q <= rx_backlog.pop_front();
                    gap_left = steady_flow ? 0 : idle_gap();
                end
                else
                    rx_valid_q <= 1'b0;
            end
        end
    end

    // Result monitor: check each taken result, stall at random, hold off on demand
    always @(posedge clk)
    begin
        if (!rst_n)
            ready_q <= 1'b0;
        else
        begin
            if (result_ch.valid && ready_q)
                check_result();
            if (hold_epoch != hold_epoch_seen)
            begin
                hold_epoch_seen = hold_epoch;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_q <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_q <= 1'b0;
            end
            else
            begin
                ready_q <= 1'b1;
                stall_left = steady_flow ? 0 : idle_gap();
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid_q <= 1'b1;
        cfg_index_q <= idx;
        cfg_data_q <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_valid_q <= 1'b0;
        case (idx)
            REG_HEADER:     cfg_header = value;
            REG_FIRST_END:  cfg_first_end = value;
            REG_SECOND_END: cfg_second_end = value;
            default:        ;
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    // Queue one packet: mostly well formed with random content, some noise or cut short
    task automatic queue_packet();
        logic [7:0] body[$];
        logic [7:0] b;
        cmd_code_t  which;
        int         pick;
        int         len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 8))
                queue_byte(8'($urandom_range(0, 255)));
            return;
        end
        which = ($urandom_range(0, 1) == 0) ? CMD_ON : CMD_OFF;
        len = (which == CMD_ON) ? int'(ON_LEN) : int'(OFF_LEN);
        if (pick < 75)
        begin
            for (int i = 0; i < len; i++)
                body.push_back(command_char(which, i));
            if (pick >= 60)
            begin
                case ($urandom_range(0, 2))
                    0:       void'(body.pop_back());
                    1:       body.push_back(payload_filler());
                    default: body[$urandom_range(0, len - 1)] = payload_filler();
                endcase
            end
        end
        else
        begin
            len = (pick < 97) ? $urandom_range(0, 12) : $urandom_range(CAPACITY - 2, CAPACITY + 12);
            for (int i = 0; i < len; i++)
                body.push_back(payload_filler());
        end
        if ($urandom_range(0, 3) == 0)
            queue_byte(8'($urandom_range(0, 255)));
        queue_byte(cfg_header);
        foreach (body[i])
            queue_byte(body[i]);
        // drop the end bytes so the next header lands inside the payload
        if (pick < 14)
            return;
        queue_byte(cfg_first_end);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == cfg_second_end);
                queue_byte(b);
            end
        end
        queue_byte(cfg_second_end);
    endtask

    task automatic queue_random_traffic(input int unsigned amount);
        int unsigned goal;
        goal = bytes_queued + amount;
        while (bytes_queued < goal)
            queue_packet();
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commands, ignored bytes in the trailer, empty payload,
        // header and zero byte inside the payload
        queue_byte(8'h00);
        queue_byte(HEADER_RESET);
        queue_text("LED_ON");
        queue_byte(FIRST_END_RESET);
        queue_byte(SECOND_END_RESET);
        queue_byte(HEADER_RESET);
        queue_text("LED_OFF");
        queue_byte(FIRST_END_RESET);
        queue_byte(FIRST_END_RESET);
        queue_byte(8'hFF);
        queue_byte(SECOND_END_RESET);
        queue_byte(HEADER_RESET);
        queue_byte(FIRST_END_RESET);
        queue_byte(SECOND_END_RESET);
        queue_byte(HEADER_RESET);
        queue_byte(HEADER_RESET);
        queue_byte(8'h00);
        queue_byte(FIRST_END_RESET);
        queue_byte(SECOND_END_RESET);
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_FIRST_END, 8'hFF);
        write_reg(REG_SECOND_END, 8'h00);
        write_reg(REG_UNUSED, 8'h40);
        steady_flow <= 1'b1;
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();
        steady_flow <= 1'b0;

        write_reg(REG_HEADER, 8'hFF);
        write_reg(REG_FIRST_END, 8'h00);
        write_reg(REG_SECOND_END, 8'hFF);
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        write_reg(REG_HEADER, 8'($urandom_range(0, 255)));
        write_reg(REG_FIRST_END, 8'($urandom_range(0, 255)));
        write_reg(REG_SECOND_END, 8'($urandom_range(0, 255)));
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        // Hold results back while bytes keep coming so the input stalls
        write_reg(REG_HEADER, HEADER_RESET);
        write_reg(REG_FIRST_END, FIRST_END_RESET);
        write_reg(REG_SECOND_END, SECOND_END_RESET);
        hold_epoch <= hold_epoch + 1;
        steady_flow <= 1'b1;
        repeat (40) queue_packet();
        wait_drained();
        steady_flow <= 1'b0;

        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        if (error_count == 0)
            $display("** text_packet_command_receiver_top: PASSED **");
        else
            $display("** text_packet_command_receiver_top: FAILED **");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("** text_packet_command_receiver_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
design/tpcr_pkg.sv
design/tpcr_ifs.sv
design/tpcr_front.sv
design/tpcr_queue.sv
design/tpcr_back.sv
design/text_packet_command_receiver_top.sv
sim/tb_top.sv
